// File: hw/rtl/stt_pkg.sv
// Shared types and constants for the sorted tick table search and insert core.
`default_nettype none

package stt_pkg;

  localparam int unsigned DefaultDepth   = 64;
  localparam int unsigned DefaultKeyBits = 32;

  typedef enum logic [1:0] {
    REQ_LOWER  = 2'd0,
    REQ_UPPER  = 2'd1,
    REQ_GET    = 2'd2,
    REQ_INSERT = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_SHIFT_PRIME,
    ST_SHIFT,
    ST_WRITE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_cmp;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic write_key;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic srch_done;
    logic need_insert;
    logic shift_done;
    logic shift_last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_tick_table_search_insert_core.sv
// Top level of the sorted tick table search and insert core.
// A lookup runs S binary-search probes, S <= ceil(log2(count+1)), each a memory read
// and a compare, then a decide step that either finishes the request or starts an insert.
// An insert then moves N entries up one slot at a cycle each, after a priming read, and writes the key last.
// Throughput: busy drops with done_o, so the next start is taken in the done_o cycle.
// Reset clears the entry count and control state, not key memory; results cannot stall.
`default_nettype none

module sorted_tick_table_search_insert_core #(
  parameter int unsigned DEPTH    = stt_pkg::DefaultDepth,
  parameter int unsigned KEY_BITS = stt_pkg::DefaultKeyBits,
  localparam int unsigned CW      = $clog2(DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [KEY_BITS-1:0] tick_key_i,
  output logic                     done_o,
  output logic [CW-1:0]            slot_o,
  output logic                     found_o,
  output logic                     inserted_o,
  output logic                     full_error_o,
  output logic [CW-1:0]            entry_count_o
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;

  stt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  stt_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .tick_key_i    (tick_key_i),
    .done_o        (done_o),
    .slot_o        (slot_o),
    .found_o       (found_o),
    .inserted_o    (inserted_o),
    .full_error_o  (full_error_o),
    .entry_count_o (entry_count_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/stt_ctrl.sv
// Controller state machine for the sorted tick table core.
`default_nettype none

module stt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire stt_pkg::sts_t sts_i,
  output stt_pkg::cmd_t      cmd_o,
  output logic               busy
);

  stt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = stt_pkg::ST_SRCH_RD;
        end
      end
      stt_pkg::ST_SRCH_RD: begin
        if (sts_i.srch_done) begin
          state_d = stt_pkg::ST_DECIDE;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = stt_pkg::ST_SRCH_CMP;
        end
      end
      stt_pkg::ST_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = stt_pkg::ST_SRCH_RD;
      end
      stt_pkg::ST_DECIDE: begin
        if (sts_i.need_insert) begin
          cmd_o.shift_init = 1'b1;
          state_d          = stt_pkg::ST_SHIFT_PRIME;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_SHIFT_PRIME: begin
        if (sts_i.shift_done) begin
          state_d = stt_pkg::ST_WRITE;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = stt_pkg::ST_SHIFT;
        end
      end
      stt_pkg::ST_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.shift_last) begin
          state_d = stt_pkg::ST_WRITE;
        end
      end
      stt_pkg::ST_WRITE: begin
        cmd_o.write_key = 1'b1;
        state_d         = stt_pkg::ST_IDLE;
      end
      default: begin
        state_d = stt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != stt_pkg::ST_IDLE);

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_idle_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(cmd_o.finish || cmd_o.write_key))
    else $error("busy dropped without a result");

  a_shift_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stt_pkg::ST_SHIFT) |->
      ($past(state_q) == stt_pkg::ST_SHIFT_PRIME || $past(state_q) == stt_pkg::ST_SHIFT))
    else $error("shift entered without priming read");

endmodule

`default_nettype wire

// File: hw/rtl/stt_dp.sv
// Datapath of the sorted tick table: key memory, search bounds, shifter and result registers.
`default_nettype none

module stt_dp #(
  parameter int unsigned DEPTH    = stt_pkg::DefaultDepth,
  parameter int unsigned KEY_BITS = stt_pkg::DefaultKeyBits,
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW      = $clog2(DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stt_pkg::cmd_t       cmd_i,
  output stt_pkg::sts_t            sts_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [KEY_BITS-1:0] tick_key_i,
  output logic                     done_o,
  output logic [CW-1:0]            slot_o,
  output logic                     found_o,
  output logic                     inserted_o,
  output logic                     full_error_o,
  output logic [CW-1:0]            entry_count_o
);

  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [CW-1:0] One  = CW'(1);

  logic [KEY_BITS-1:0] mem [DEPTH];

  stt_pkg::req_e       req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d, count_q, count_d;
  logic                eq_q, eq_d;
  logic [KEY_BITS-1:0] rd_data_q;
  logic                done_q;
  logic [CW-1:0]       slot_q, cnt_res_q;
  logic                found_q, inserted_q, full_q;

  logic [CW-1:0]       mid, ptr_m1, ptr_m2;
  logic                rd_en, wr_en, go_right, strict;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_m1 = ptr_q - One;
  assign ptr_m2 = ptr_q - CW'(2);
  assign strict = (req_q != stt_pkg::REQ_LOWER);
  assign go_right = strict ? (rd_data_q <= key_q) : (rd_data_q < key_q);

  assign sts_o.srch_done   = (lo_q >= hi_q);
  assign sts_o.need_insert = (req_q == stt_pkg::REQ_INSERT) && !eq_q && (count_q < Full);
  assign sts_o.shift_done  = (ptr_q == lo_q);
  assign sts_o.shift_last  = (ptr_m1 == lo_q);

  // Read port: the search probe, or the entry below the shift pointer.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid[AW-1:0];
    priority if (cmd_i.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid[AW-1:0];
    end else if (cmd_i.shift_rd) begin
      rd_en   = 1'b1;
      rd_addr = ptr_m1[AW-1:0];
    end else if (cmd_i.shift_wr) begin
      rd_en   = !sts_o.shift_last;
      rd_addr = ptr_m2[AW-1:0];
    end else begin
      rd_en   = 1'b0;
      rd_addr = mid[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd_i.shift_wr || cmd_i.write_key;
    wr_addr = cmd_i.write_key ? lo_q[AW-1:0] : ptr_q[AW-1:0];
    wr_data = cmd_i.write_key ? key_q : rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Bounds, shift pointer and entry count. A right move records whether the probed key
  // matched; the last right move lands on the slot just below the upper bound.
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    eq_d    = eq_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
      eq_d = 1'b0;
    end
    if (cmd_i.srch_cmp) begin
      if (go_right) begin
        lo_d = mid + One;
        eq_d = (rd_data_q == key_q);
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.shift_init) begin
      ptr_d = count_q;
    end
    if (cmd_i.shift_wr) begin
      ptr_d = ptr_m1;
    end
    if (cmd_i.write_key) begin
      count_d = count_q + One;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hi_q    <= '0;
      eq_q    <= 1'b0;
      ptr_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      eq_q    <= eq_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      done_q  <= cmd_i.finish || cmd_i.write_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= stt_pkg::req_e'(req_type_i);
      key_q <= tick_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_key) begin
      slot_q     <= lo_q;
      found_q    <= 1'b0;
      inserted_q <= 1'b1;
      full_q     <= 1'b0;
      cnt_res_q  <= count_d;
    end else if (cmd_i.finish) begin
      inserted_q <= 1'b0;
      cnt_res_q  <= count_q;
      unique case (req_q)
        stt_pkg::REQ_LOWER, stt_pkg::REQ_UPPER: begin
          slot_q  <= lo_q;
          found_q <= 1'b0;
          full_q  <= 1'b0;
        end
        stt_pkg::REQ_GET, stt_pkg::REQ_INSERT: begin
          slot_q  <= eq_q ? (lo_q - One) : '0;
          found_q <= eq_q;
          full_q  <= !eq_q && (req_q == stt_pkg::REQ_INSERT);
        end
        default: begin
          slot_q  <= '0;
          found_q <= 1'b0;
          full_q  <= 1'b0;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign found_o       = found_q;
  assign inserted_o    = inserted_q;
  assign full_error_o  = full_q;
  assign entry_count_o = cnt_res_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count beyond table depth");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_key |=> (count_q == $past(count_q) + One))
    else $error("insert did not bump the entry count");

  a_result_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($countones({found_o, inserted_o, full_error_o}) <= 1))
    else $error("result beat carries conflicting flags");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the sorted tick table search and insert core.
module tb;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned CW          = $clog2(DEPTH + 1);
  localparam int unsigned TOTAL_ITEMS = 1100;
  localparam int unsigned LIMIT       = 600000;
  localparam int unsigned SETTLE      = 90;

  typedef struct packed {
    logic [CW-1:0] slot;
    logic          found;
    logic          inserted;
    logic          full_error;
    logic [CW-1:0] entry_count;
  } tick_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic [1:0]          req_type_i    = stt_pkg::REQ_LOWER;
  logic [KEY_BITS-1:0] tick_key_i    = '0;
  logic                busy;
  logic                done_o;
  logic [CW-1:0]       slot_o;
  logic                found_o;
  logic                inserted_o;
  logic                full_error_o;
  logic [CW-1:0]       entry_count_o;

  // Shadow copy of the table, kept in ascending order.
  logic [KEY_BITS-1:0] table_keys [DEPTH];
  int unsigned         table_count = 0;
  tick_result_t        pending_results [$];
  tick_result_t        oldest;
  int unsigned         error_count = 0;
  int unsigned         items_sent  = 0;
  int unsigned         burst_left  = 0;
  int unsigned         cycle_count = 0;

  sorted_tick_table_search_insert_core #(
    .DEPTH   (DEPTH),
    .KEY_BITS(KEY_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .tick_key_i   (tick_key_i),
    .done_o       (done_o),
    .slot_o       (slot_o),
    .found_o      (found_o),
    .inserted_o   (inserted_o),
    .full_error_o (full_error_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Since the table is sorted, a bound is just the number of keys below it, or at or below it for an upper bound.
  function automatic int unsigned count_below(logic [KEY_BITS-1:0] key, bit with_equal);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < table_count; i++) begin
      if (table_keys[i] < key || (with_equal && table_keys[i] == key)) n++;
    end
    return n;
  endfunction

  function automatic tick_result_t predict_request(stt_pkg::req_e kind,
                                                   logic [KEY_BITS-1:0] key);
    tick_result_t r;
    int unsigned  ub;
    r = '0;
    ub = count_below(key, 1'b1);
    case (kind)
      stt_pkg::REQ_LOWER: begin
        r.slot = CW'(count_below(key, 1'b0));
      end
      stt_pkg::REQ_UPPER: begin
        r.slot = CW'(ub);
      end
      default: begin
        if (ub > 0 && table_keys[ub-1] == key) begin
          r.slot  = CW'(ub - 1);
          r.found = 1'b1;
        end else if (kind == stt_pkg::REQ_INSERT) begin
          if (table_count < DEPTH) begin
            for (int unsigned i = table_count; i > ub; i--) table_keys[i] = table_keys[i-1];
            table_keys[ub] = key;
            table_count++;
            r.slot     = CW'(ub);
            r.inserted = 1'b1;
          end else begin
            r.full_error = 1'b1;
          end
        end
      end
    endcase
    r.entry_count = CW'(table_count);
    return r;
  endfunction

  // Keys cluster around stored entries so that bounds and matches are hit often.
  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [KEY_BITS-1:0] k;
    int unsigned         sel;
    sel = $urandom_range(0, 99);
    if (table_count > 0 && sel < 45) begin
      k = table_keys[$urandom_range(0, table_count - 1)];
      if (sel >= 30) k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
    end else if (sel < 55) begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = 1;
        2:       k = '1 - 1'b1;
        default: k = '1;
      endcase
    end else if (sel < 65) begin
      k = $urandom_range(0, 255);
    end else begin
      k = $urandom();
    end
    return k;
  endfunction

  function automatic stt_pkg::req_e pick_kind(int unsigned insert_weight);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < insert_weight) return stt_pkg::REQ_INSERT;
    case (sel % 3)
      0:       return stt_pkg::REQ_LOWER;
      1:       return stt_pkg::REQ_UPPER;
      default: return stt_pkg::REQ_GET;
    endcase
  endfunction

  task automatic send_request(stt_pkg::req_e kind, logic [KEY_BITS-1:0] key);
    req_type_i <= kind;
    tick_key_i <= key;
    start      <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(predict_request(kind, key));
    items_sent++;
  endtask

  // Sender bursts: start stays high within a burst and drops for a random gap after it.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap        = $urandom_range(1, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_request(stt_pkg::REQ_LOWER, '0);
    send_request(stt_pkg::REQ_UPPER, '1);
    send_request(stt_pkg::REQ_GET, '0);
    send_request(stt_pkg::REQ_GET, '1);
    send_request(stt_pkg::REQ_INSERT, '1);
    send_request(stt_pkg::REQ_INSERT, '0);
    send_request(stt_pkg::REQ_INSERT, '0);
    send_request(stt_pkg::REQ_GET, '0);
    send_request(stt_pkg::REQ_LOWER, '1);
    send_request(stt_pkg::REQ_UPPER, '1);
    send_request(stt_pkg::REQ_UPPER, '0);
    send_request(stt_pkg::REQ_LOWER, '0);
    send_request(stt_pkg::REQ_GET, 7);
    send_request(stt_pkg::REQ_INSERT, 7);
    send_request(stt_pkg::REQ_GET, 7);
    wait_drained();
  endtask

  task automatic test_random_growth();
    while (table_count < DEPTH && items_sent < TOTAL_ITEMS / 2) begin
      send_request(pick_kind(35), pick_key());
      pace();
    end
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [KEY_BITS-1:0] absent;
    while (table_count < DEPTH) send_request(stt_pkg::REQ_INSERT, $urandom());
    do absent = $urandom(); while (count_below(absent, 1'b1) != count_below(absent, 1'b0));
    send_request(stt_pkg::REQ_INSERT, absent);
    send_request(stt_pkg::REQ_INSERT, '1);
    send_request(stt_pkg::REQ_GET, absent);
    send_request(stt_pkg::REQ_LOWER, '1);
    send_request(stt_pkg::REQ_UPPER, '1);
    send_request(stt_pkg::REQ_LOWER, '0);
    wait_drained();
  endtask

  task automatic test_random_full();
    while (items_sent < TOTAL_ITEMS) begin
      send_request(pick_kind(25), pick_key());
      pace();
    end
    wait_drained();
  endtask

  function automatic void check_field(string what, logic [CW-1:0] want, logic [CW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Each result beat is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got slot %0d count %0d",
                 $time, slot_o, entry_count_o);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("slot", oldest.slot, slot_o);
        check_field("found", CW'(oldest.found), CW'(found_o));
        check_field("inserted", CW'(oldest.inserted), CW'(inserted_o));
        check_field("full_error", CW'(oldest.full_error), CW'(full_error_o));
        check_field("entry_count", oldest.entry_count, entry_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_random_growth();
    test_full_table();
    test_random_full();
    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
